// ----- rtl/core/tvi_pkg.sv -----
`timescale 1ns / 1ps
package tvi_pkg;

   // fixed field widths
   localparam int DUR_W     = 24;
   localparam int VAL_W     = 32;
   localparam int ELAPSED_W = 16;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 2;
   localparam int MUL_W     = 33;

   // q30 constants, a q24 power exponent and the last taylor term index
   localparam logic [31:0] PI_Q30         = 32'd3373259426;
   localparam logic [32:0] ONE_Q30        = 33'h040000000;
   localparam logic [30:0] HALF_Q30       = 31'h20000000;
   localparam logic [23:0] FAST_POWER_Q24 = 24'h4CCCCC;
   localparam logic [2:0]  TAYLOR_LAST    = 3'd6;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_LINEAR     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_EASE       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_STAY_START = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STAY_END   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FAST       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_SLOW       = 3'd5;
   localparam logic [MODE_W-1:0] MODE_LIMIT      = 3'd6;

   // request operations
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 2'd3;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DIV_WAIT,
      ST_SHAPE,
      ST_SLOW,
      ST_FAST_LO,
      ST_FAST_HI,
      ST_FAST_MUL,
      ST_FAST_ADD,
      ST_EASE_THETA,
      ST_EASE_SQR,
      ST_EASE_TH2,
      ST_EASE_MUL,
      ST_EASE_DIV,
      ST_EASE_WAIT,
      ST_EASE_POW,
      ST_EASE_RND,
      ST_LERP_MUL,
      ST_LERP_ADD,
      ST_OUTPUT
   } state_type;

   // reciprocals of the taylor divisors (2n)(2n+1), ceil(2^(32+l) / d), l = ceil(log2 d)
   function automatic logic [MUL_W-1:0] taylor_recip(input logic [2:0] n);
      logic [MUL_W-1:0] m;
      unique case (n)
         3'd1: m = MUL_W'(((64'd1 << 35) + 64'd5) / 64'd6);
         3'd2: m = MUL_W'(((64'd1 << 37) + 64'd19) / 64'd20);
         3'd3: m = MUL_W'(((64'd1 << 38) + 64'd41) / 64'd42);
         3'd4: m = MUL_W'(((64'd1 << 39) + 64'd71) / 64'd72);
         3'd5: m = MUL_W'(((64'd1 << 39) + 64'd109) / 64'd110);
         3'd6: m = MUL_W'(((64'd1 << 40) + 64'd155) / 64'd156);
         default: m = MUL_W'(((64'd1 << 35) + 64'd5) / 64'd6);
      endcase
      return m;
   endfunction

   // quotient from the reciprocal product, shifted by 32 + l
   function automatic logic [31:0] taylor_quot(input logic [2:0] n,
                                               input logic [2*MUL_W-1:0] p);
      logic [31:0] q;
      unique case (n)
         3'd1:       q = 32'(p[64:35]);
         3'd2:       q = 32'(p[64:37]);
         3'd3:       q = 32'(p[64:38]);
         3'd4, 3'd5: q = 32'(p[64:39]);
         3'd6:       q = 32'(p[64:40]);
         default:    q = 32'(p[64:35]);
      endcase
      return q;
   endfunction

   // integer square root, evaluated at elaboration for the power table
   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // x^0.3 table entry at x = k / 2^abits, rounded to fbits fraction bits
   function automatic logic [63:0] fast_entry(input int k, input int abits, input int fbits);
      logic [63:0] r;
      logic [63:0] acc;
      r = (64'(k) << 30) >> abits;
      acc = 64'd1 << 30;
      for (int i = 1; i <= 24; i++) begin
         r = isqrt64(r << 30);
         if (FAST_POWER_Q24[24-i]) acc = (acc * r) >> 30;
      end
      return (acc + (64'd1 << (29 - fbits))) >> (30 - fbits);
   endfunction

endpackage

// ----- rtl/core/tvi_mul.sv -----
`timescale 1ns / 1ps
module tvi_mul import tvi_pkg::*; (
   input  logic                 clock,
   input  logic [MUL_W-1:0]     mul_a,
   input  logic [MUL_W-1:0]     mul_b,
   output logic [2*MUL_W-1:0]   prod_ff
);

   // shared registered multiplier
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

// ----- rtl/core/tvi_div.sv -----
`timescale 1ns / 1ps
module tvi_div import tvi_pkg::*; #(
   parameter int NUM_W = 40,
   parameter int CNT_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   num,
   input  logic [DUR_W-1:0]   den,
   input  logic [CNT_W-1:0]   steps,
   output logic [NUM_W-1:0]   quot,
   output div_status_type     stat
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [DUR_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   shift_ff, shift_in;
   logic [DUR_W:0]     trial;
   logic [DUR_W:0]     diff;
   logic               ge;

   // one restoring step per cycle, quotient bits shift in at the bottom
   assign trial = {rem_ff, shift_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den};
   assign diff  = trial - {1'b0, den};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = steps;
         rem_in   = '0;
         shift_in = num;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
         shift_in = {shift_ff[NUM_W-2:0], ge};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign quot      = shift_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ----- rtl/core/tvi_rom.sv -----
`timescale 1ns / 1ps
module tvi_rom import tvi_pkg::*; #(
   parameter int ADDR_BITS = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic [ADDR_BITS:0]   addr,
   output logic [FRAC_BITS:0]   data_ff
);

   localparam int SIZE = (1 << ADDR_BITS) + 1;

   logic [FRAC_BITS:0] rom_data [SIZE];

   // x^0.3 table built at elaboration
   for (genvar k = 0; k < SIZE; k++) begin : g_entry
      localparam logic [63:0] ENTRY = fast_entry(k, ADDR_BITS, FRAC_BITS);
      assign rom_data[k] = ENTRY[FRAC_BITS:0];
   end

   // registered read
   always_ff @(posedge clock) begin
      data_ff <= rom_data[addr];
   end

endmodule

// ----- rtl/core/timed_value_interpolator.sv -----
`timescale 1ns / 1ps
// channel   direction  ports                                   handshake
// req       in         req_operation, req_elapsed_ms           req_valid / req_ready
// rsp       out        rsp_value, rsp_finished, rsp_status     rsp_valid / rsp_ready
// csr       in         csr_index, csr_data                     csr_valid / csr_ready
//
// one request at a time; req_ready is high only while the sequencer is idle
// linear and stay modes: progress is computed by the bit-serial divider;
// slow adds a squaring step, fast adds a table lookup with interpolation
// zero duration skips the divider
// ease mode adds six taylor terms, each a multiply and a reciprocal multiply
// the result waits in an output register, so a new request is taken while it is unread
// synchronous active-high reset; no clearing pass, the power table is constant
module timed_value_interpolator import tvi_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 8,
   parameter int FRACTION_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic [ELAPSED_W-1:0]        req_elapsed_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [VAL_W-1:0]     rsp_value,
   output logic                        rsp_finished,
   output logic                        rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [VAL_W-1:0]            csr_data
);

   localparam int F     = FRACTION_BITS;
   localparam int A     = TABLE_ADDR_BITS;
   localparam int NUM_W = DUR_W + F;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int P_W   = MUL_W + F;
   localparam logic [F:0] ONE_T = {1'b1, {F{1'b0}}};
   localparam logic [A:0] ROM_LAST = {1'b1, {A{1'b0}}};

   state_type state_ff, state_in;

   // configuration and run state
   logic [MODE_W-1:0] mode_ff;
   logic [VAL_W-1:0]  start_ff;
   logic [VAL_W-1:0]  end_ff;
   logic [DUR_W-1:0]  dur_ff;
   logic [DUR_W-1:0]  elapsed_ff;
   logic              done_ff;
   logic [VAL_W-1:0]  held_ff;
   logic              stat_ff;

   // working registers
   logic [F:0]        t_ff;
   logic [F:0]        s_ff;
   logic [F:0]        lo_ff;
   logic [MUL_W-1:0]  term_ff;
   logic [MUL_W-1:0]  sum_ff;
   logic [MUL_W-1:0]  th2_ff;
   logic [2:0]        n_ff;

   // output register
   logic              rsp_valid_ff;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic              rsp_finished_ff;
   logic              rsp_status_ff;

   // shared units
   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [2*MUL_W-1:0]  mul_p;
   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   logic [DUR_W-1:0]    div_den;
   logic [CNT_W-1:0]    div_steps;
   logic [NUM_W-1:0]    div_quot;
   div_status_type      div_stat;
   logic [A:0]          rom_addr;
   logic [F:0]          rom_q;

   logic              accept;
   logic              mode_bad;
   logic              out_free;

   // elapsed time update on accept
   logic [DUR_W:0]    el_sum;
   logic [DUR_W-1:0]  el_base;
   logic [ELAPSED_W-1:0] el_ms;

   // progress clamp
   logic [F:0]        t_div;

   // slow mode rounding
   logic [2*F+1:0]    slow_r;
   logic [F+1:0]      slow_q;
   logic [F:0]        slow_s;

   // fast mode table lookup
   logic [F+A:0]      fast_u;
   logic [A:0]        fast_idx;
   logic [F-1:0]      fast_fr;
   logic              fast_clamp;
   logic [F:0]        fast_hi;
   logic [F:0]        fast_diff;
   logic [F+1:0]      fast_sum;
   logic [F:0]        fast_s;

   // ease mode
   logic [30:0]       ease_t30;
   logic [30:0]       ease_fold;
   logic [31:0]       ease_term;
   logic [MUL_W-1:0]  ease_sum;
   logic [MUL_W-1:0]  ease_s30;
   logic [31:0]       ease_rnd;
   logic [F+1:0]      ease_q;
   logic [F:0]        ease_s;

   // lerp
   logic [MUL_W-1:0]  lerp_diff;
   logic              lerp_neg;
   logic [MUL_W-1:0]  lerp_mag;
   logic [P_W:0]      lerp_rnd;
   logic [MUL_W-1:0]  lerp_q;
   logic [MUL_W-1:0]  lerp_val;

   tvi_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_p)
   );

   tvi_div #(.NUM_W(NUM_W), .CNT_W(CNT_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   tvi_rom #(.ADDR_BITS(A), .FRAC_BITS(F)) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .data_ff (rom_q)
   );

   assign accept   = req_valid && req_ready;
   assign mode_bad = mode_ff >= MODE_LIMIT;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // elapsed time, clamped at the duration
   always_comb begin
      el_base = (req_operation == OP_START) ? '0 : elapsed_ff;
      el_ms   = (req_operation == OP_START) ? '0 : req_elapsed_ms;
      el_sum  = (DUR_W+1)'(el_base) + (DUR_W+1)'(el_ms);
   end

   // progress from the divider
   assign t_div = (div_quot > NUM_W'(ONE_T)) ? ONE_T : div_quot[F:0];

   // slow: t squared, rounded
   always_comb begin
      slow_r = mul_p[2*F+1:0] + ((2*F+2)'(1) << (F - 1));
      slow_q = slow_r[2*F+1:F];
      slow_s = (slow_q > (F+2)'(ONE_T)) ? ONE_T : slow_q[F:0];
   end

   // fast: index and fraction into the power table
   always_comb begin
      fast_u     = {t_ff, {A{1'b0}}};
      fast_idx   = fast_u[F+A:F];
      fast_fr    = fast_u[F-1:0];
      fast_clamp = fast_idx[A];
      fast_hi    = (rom_q < lo_ff) ? lo_ff : rom_q;
      fast_diff  = fast_hi - lo_ff;
      fast_sum   = (F+2)'(lo_ff) + mul_p[2*F+1:F];
      fast_s     = (fast_sum > (F+2)'(ONE_T)) ? ONE_T : fast_sum[F:0];
   end

   // ease: fold, taylor term update, final square rounding
   always_comb begin
      ease_t30  = {t_ff, {(30-F){1'b0}}};
      ease_fold = (ease_t30 > 31'(HALF_Q30)) ? 31'(ONE_Q30) - ease_t30 : ease_t30;
      ease_term = taylor_quot(n_ff, mul_p);
      if (n_ff[0]) begin
         ease_sum = (sum_ff >= MUL_W'(ease_term)) ? sum_ff - MUL_W'(ease_term) : '0;
      end else begin
         ease_sum = sum_ff + MUL_W'(ease_term);
      end
      ease_s30 = (sum_ff > ONE_Q30) ? ONE_Q30 : sum_ff;
      ease_rnd = 32'(mul_p[60:30]) + (32'd1 << (29 - F));
      ease_q   = ease_rnd[31-F+F+1-1 -: F+2];
      ease_s   = (ease_q > (F+2)'(ONE_T)) ? ONE_T : ease_q[F:0];
   end

   // lerp with half-up rounding of the scaled difference
   always_comb begin
      lerp_diff = {end_ff[VAL_W-1], end_ff} - {start_ff[VAL_W-1], start_ff};
      lerp_neg  = lerp_diff[MUL_W-1];
      lerp_mag  = lerp_neg ? -lerp_diff : lerp_diff;
      lerp_rnd  = (P_W+1)'(mul_p[P_W-1:0]) + ((P_W+1)'(1) << (F - 1))
                  - (P_W+1)'(lerp_neg);
      lerp_q    = lerp_rnd[F+MUL_W-1:F];
      lerp_val  = {start_ff[VAL_W-1], start_ff} + (lerp_neg ? -lerp_q : lerp_q);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = mode_bad ? ST_OUTPUT : ST_DIVIDE;
         ST_DIVIDE:     state_in = (dur_ff == '0) ? ST_SHAPE : ST_DIV_WAIT;
         ST_DIV_WAIT:   if (div_stat.done) state_in = ST_SHAPE;
         ST_SHAPE: begin
            case (mode_ff)
               MODE_SLOW: state_in = ST_SLOW;
               MODE_FAST: state_in = ST_FAST_LO;
               MODE_EASE: state_in = ST_EASE_THETA;
               default:   state_in = ST_LERP_MUL;
            endcase
         end
         ST_SLOW:       state_in = ST_LERP_MUL;
         ST_FAST_LO:    state_in = ST_FAST_HI;
         ST_FAST_HI:    state_in = ST_FAST_MUL;
         ST_FAST_MUL:   state_in = fast_clamp ? ST_LERP_MUL : ST_FAST_ADD;
         ST_FAST_ADD:   state_in = ST_LERP_MUL;
         ST_EASE_THETA: state_in = ST_EASE_SQR;
         ST_EASE_SQR:   state_in = ST_EASE_TH2;
         ST_EASE_TH2:   state_in = ST_EASE_MUL;
         ST_EASE_MUL:   state_in = ST_EASE_DIV;
         ST_EASE_DIV:   state_in = ST_EASE_WAIT;
         ST_EASE_WAIT: begin
            state_in = (n_ff == TAYLOR_LAST) ? ST_EASE_POW : ST_EASE_MUL;
         end
         ST_EASE_POW:   state_in = ST_EASE_RND;
         ST_EASE_RND:   state_in = ST_LERP_MUL;
         ST_LERP_MUL:   state_in = ST_LERP_ADD;
         ST_LERP_ADD:   state_in = ST_OUTPUT;
         ST_OUTPUT:     if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // unit controls per state
   always_comb begin
      req_ready = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      div_num   = NUM_W'(elapsed_ff) << F;
      div_den   = dur_ff;
      div_steps = CNT_W'(NUM_W);
      rom_addr  = fast_clamp ? ROM_LAST : fast_idx;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_DIVIDE: div_start = (dur_ff != '0);
         ST_SHAPE: begin
            if (mode_ff == MODE_SLOW) begin
               mul_a = MUL_W'(t_ff);
               mul_b = MUL_W'(t_ff);
            end else begin
               mul_a = MUL_W'(PI_Q30);
               mul_b = MUL_W'(ease_fold);
            end
         end
         ST_FAST_HI: rom_addr = fast_clamp ? ROM_LAST : fast_idx + 1'b1;
         ST_FAST_MUL: begin
            mul_a = MUL_W'(fast_diff);
            mul_b = MUL_W'(fast_fr);
         end
         ST_EASE_SQR: begin
            mul_a = term_ff;
            mul_b = term_ff;
         end
         ST_EASE_MUL: begin
            mul_a = term_ff;
            mul_b = th2_ff;
         end
         // divide by the taylor divisor as a reciprocal product
         ST_EASE_DIV: begin
            mul_a = MUL_W'(mul_p[61:30]);
            mul_b = taylor_recip(n_ff);
         end
         ST_EASE_POW: begin
            mul_a = ease_s30;
            mul_b = ease_s30;
         end
         ST_LERP_MUL: begin
            mul_a = lerp_mag;
            mul_b = MUL_W'(s_ff);
         end
         default: ;
      endcase
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_LINEAR;
         start_ff     <= '0;
         end_ff       <= '0;
         dur_ff       <= '0;
         elapsed_ff   <= '0;
         done_ff      <= 1'b1;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // register writes
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MODE: begin
                  if (done_ff && (csr_data[MODE_W-1:0] < MODE_LIMIT))
                     mode_ff <= csr_data[MODE_W-1:0];
               end
               CSR_START:    start_ff <= csr_data;
               CSR_END:      end_ff   <= csr_data;
               CSR_DURATION: dur_ff   <= csr_data[DUR_W-1:0];
               default: ;
            endcase
         end
         // elapsed time on accept
         if (accept && !mode_bad) begin
            if (el_sum >= {1'b0, dur_ff}) begin
               elapsed_ff <= dur_ff;
               done_ff    <= 1'b1;
            end else begin
               elapsed_ff <= el_sum[DUR_W-1:0];
               if (req_operation == OP_START) done_ff <= 1'b0;
            end
         end
         if (state_ff == ST_LERP_ADD) held_ff <= lerp_val[VAL_W-1:0];
         // output register
         if (state_ff == ST_OUTPUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) stat_ff <= mode_bad;
      case (state_ff)
         ST_DIVIDE:   if (dur_ff == '0) t_ff <= ONE_T;
         ST_DIV_WAIT: if (div_stat.done) t_ff <= t_div;
         ST_SHAPE: begin
            case (mode_ff)
               MODE_STAY_START: s_ff <= '0;
               MODE_STAY_END:   s_ff <= ONE_T;
               default:         s_ff <= t_ff;
            endcase
         end
         ST_SLOW:     s_ff <= slow_s;
         ST_FAST_HI:  lo_ff <= rom_q;
         ST_FAST_MUL: if (fast_clamp) s_ff <= lo_ff;
         ST_FAST_ADD: s_ff <= fast_s;
         ST_EASE_THETA: begin
            term_ff <= mul_p[62:30];
            sum_ff  <= mul_p[62:30];
         end
         ST_EASE_TH2: begin
            th2_ff <= mul_p[62:30];
            n_ff   <= 3'd1;
         end
         ST_EASE_WAIT: begin
            term_ff <= MUL_W'(ease_term);
            sum_ff  <= ease_sum;
            n_ff    <= n_ff + 3'd1;
         end
         ST_EASE_RND: s_ff <= ease_s;
         ST_OUTPUT: begin
            if (out_free) begin
               rsp_value_ff    <= held_ff;
               rsp_finished_ff <= done_ff;
               rsp_status_ff   <= stat_ff;
            end
         end
         default: ;
      endcase
   end

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_finished = rsp_finished_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second request taken during a computation");

   a_elapsed_clamped: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> elapsed_ff <= dur_ff)
      else $error("elapsed time beyond duration");

   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHAPE |-> t_ff <= ONE_T)
      else $error("progress above one");

   a_mode_valid: assert property (@(posedge clock) disable iff (reset)
      mode_ff < MODE_LIMIT)
      else $error("mode register holds an invalid code");

endmodule

// ----- test/timed_value_interpolator_tb.sv -----
`timescale 1ns / 1ps
module timed_value_interpolator_tb;
   import tvi_pkg::*;

   localparam int TAB_BITS  = 8;
   localparam int FRAC      = 16;
   localparam int TAB_SIZE  = (1 << TAB_BITS) + 1;
   localparam longint ONE_F = 64'd1 << FRAC;
   localparam longint UNITY_Q30 = 64'd1 << 30;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 400;

   // tracks the interpolator state and the results it should produce
   class interp_tracker;
      logic [MODE_W-1:0]       cur_mode;
      logic signed [VAL_W-1:0] from_value;
      logic signed [VAL_W-1:0] to_value;
      logic [DUR_W-1:0]        length_ms;
      logic [DUR_W-1:0]        elapsed_acc;
      logic                    run_done;
      logic signed [VAL_W-1:0] last_value;
      longint unsigned         power_rom[TAB_SIZE];
      logic [VAL_W+1:0]        expected_values[$];
      int                      mismatches;

      function automatic longint unsigned int_sqrt(longint unsigned v_in);
         longint unsigned v, r, b;
         v = v_in;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function automatic longint unsigned to_frac(longint unsigned q);
         return (q + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      endfunction

      function new();
         longint unsigned r, acc;
         for (int k = 0; k < TAB_SIZE; k++) begin
            r = (64'(k) << 30) >> TAB_BITS;
            acc = UNITY_Q30;
            for (int i = 1; i <= 24; i++) begin
               r = int_sqrt(r << 30);
               if ((24'h4CCCCC >> (24 - i)) & 1) acc = (acc * r) >> 30;
            end
            power_rom[k] = to_frac(acc);
         end
         cur_mode    = MODE_LINEAR;
         from_value  = 0;
         to_value    = 0;
         length_ms   = 0;
         elapsed_acc = 0;
         run_done    = 1'b1;
         last_value  = 0;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
         case (idx)
            CSR_MODE: if (run_done && data[MODE_W-1:0] < MODE_LIMIT) cur_mode = data[MODE_W-1:0];
            CSR_START: from_value = data;
            CSR_END: to_value = data;
            CSR_DURATION: length_ms = data[DUR_W-1:0];
         endcase
      endfunction

      // sin^2 of pi t, folded to the first half
      function automatic longint unsigned ease_curve(longint unsigned t);
         longint unsigned t30, theta, th2, term, sum;
         t30 = t << (30 - FRAC);
         if (t30 > (UNITY_Q30 >> 1)) t30 = UNITY_Q30 - t30;
         theta = (64'(PI_Q30) * t30) >> 30;
         th2 = (theta * theta) >> 30;
         term = theta;
         sum = theta;
         for (int n = 1; n <= 6; n++) begin
            term = (term * th2) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n & 1) sum = (sum >= term) ? sum - term : 0;
            else sum = sum + term;
         end
         if (sum > UNITY_Q30) sum = UNITY_Q30;
         return to_frac((sum * sum) >> 30);
      endfunction

      // table lookup of t^0.3 with linear interpolation
      function automatic longint unsigned fast_curve(longint unsigned t);
         longint unsigned u, idx, fr, lo, hi;
         u = t << TAB_BITS;
         idx = u >> FRAC;
         fr = u & (ONE_F - 1);
         if (idx >= TAB_SIZE - 1) return power_rom[TAB_SIZE - 1];
         lo = power_rom[idx];
         hi = power_rom[idx + 1];
         if (hi < lo) hi = lo;
         return lo + (((hi - lo) * fr) >> FRAC);
      endfunction

      function void note_request(logic op, logic [ELAPSED_W-1:0] ms);
         longint unsigned sum, t, s;
         longint p, a, b;
         if (cur_mode >= MODE_LIMIT) begin
            expected_values.push_back({last_value, run_done, 1'b1});
            return;
         end
         sum = ms;
         if (op == OP_START) begin
            elapsed_acc = 0;
            run_done = 1'b0;
            sum = 0;
         end
         sum = sum + elapsed_acc;
         if (sum >= length_ms) begin
            sum = length_ms;
            run_done = 1'b1;
         end
         elapsed_acc = sum;
         if (length_ms == 0) t = ONE_F;
         else t = (64'(elapsed_acc) << FRAC) / length_ms;
         if (t > ONE_F) t = ONE_F;
         case (cur_mode)
            MODE_EASE: s = ease_curve(t);
            MODE_STAY_START: s = 0;
            MODE_STAY_END: s = ONE_F;
            MODE_FAST: s = fast_curve(t);
            MODE_SLOW: s = (t * t + (ONE_F >> 1)) >> FRAC;
            default: s = t;
         endcase
         if (s > ONE_F) s = ONE_F;
         a = from_value;
         b = to_value;
         p = (b - a) * longint'(s) + longint'(ONE_F >> 1);
         last_value = a + (p >>> FRAC);
         expected_values.push_back({last_value, run_done, 1'b0});
      endfunction

      function void check_result(logic signed [VAL_W-1:0] value, logic fin, logic stat);
         logic [VAL_W+1:0] want;
         if (expected_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result value=%0d finished=%0b status=%0b", value, fin, stat);
            return;
         end
         want = expected_values.pop_front();
         if (want != {value, fin, stat}) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected value=%0d finished=%0b status=%0b, got %0d %0b %0b",
                        $signed(want[VAL_W+1:2]), want[1], want[0], value, fin, stat);
         end
      endfunction

      function int pending();
         return expected_values.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_operation;
   logic [ELAPSED_W-1:0]    req_elapsed_ms;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [VAL_W-1:0] rsp_value;
   logic                    rsp_finished;
   logic                    rsp_status;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [VAL_W-1:0]        csr_data;

   interp_tracker tracker = new();
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_cycles;
   logic hold_off_go;
   logic hold_off_started;
   int quiet_cycles;
   int item_count;
   logic [DUR_W-1:0] dur_now;

   timed_value_interpolator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation), .req_elapsed_ms(req_elapsed_ms),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_value(rsp_value), .rsp_finished(rsp_finished), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watch the three channels and keep the tracker in step
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_data);
         if (req_valid && req_ready) tracker.note_request(req_operation, req_elapsed_ms);
         if (rsp_valid && rsp_ready) tracker.check_result(rsp_value, rsp_finished, rsp_status);
      end
   end

   // receiver readiness, with one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready        <= 1'b0;
         hold_off_cycles  <= 0;
         hold_off_started <= 1'b0;
      end else if (hold_off_go && !hold_off_started) begin
         hold_off_started <= 1'b1;
         hold_off_cycles  <= 3000;
         rsp_ready        <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timed_value_interpolator_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_request(logic op, logic [ELAPSED_W-1:0] ms);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_elapsed_ms <= ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
   endtask

   // let every result arrive and the block settle before touching registers
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic [2:0] m, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                            logic [DUR_W-1:0] d);
      write_reg(CSR_MODE, {29'($urandom()), m});
      write_reg(CSR_START, a);
      write_reg(CSR_END, b);
      write_reg(CSR_DURATION, {8'($urandom()), d});
      dur_now = d;
   endtask

   // elapsed step sized to the duration, with some full-range noise
   function automatic logic [ELAPSED_W-1:0] pick_step();
      int r;
      r = $urandom_range(99);
      if (r < 15) return ELAPSED_W'($urandom());
      if (r < 20) return '0;
      if (dur_now > 65535) return ELAPSED_W'($urandom());
      return ELAPSED_W'($urandom_range(32'(dur_now / 3) + 32'd1, 0));
   endfunction

   initial begin
      logic [2:0] m;
      logic [DUR_W-1:0] d;
      int phase;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_TICK;
      req_elapsed_ms = '0;
      csr_valid = 1'b0;
      csr_index = CSR_MODE;
      csr_data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_go = 1'b0;
      item_count = 0;
      dur_now = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: each mode over a short run, ticks past the end
      for (int k = 0; k < 6; k++) begin
         configure(k[2:0], 32'sh0001_0000, -32'sh0003_0000, 24'd100);
         send_request(OP_START, 16'hFFFF);
         send_request(OP_TICK, 16'd37);
         send_request(OP_TICK, 16'hFFFF);
         drain();
      end
      // invalid modes are ignored, extremes of the values, zero duration
      write_reg(CSR_MODE, 32'd6);
      write_reg(CSR_MODE, 32'd7);
      configure(MODE_LINEAR, 32'h8000_0000, 32'h7FFF_FFFF, 24'd0);
      send_request(OP_START, 16'd0);
      drain();
      configure(MODE_SLOW, 32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF);
      send_request(OP_START, 16'd0);
      send_request(OP_TICK, 16'hFFFF);
      drain();
      // mode write ignored mid-run, duration lowered mid-run
      write_reg(CSR_MODE, 32'(MODE_STAY_END));
      write_reg(CSR_DURATION, 32'd1000);
      send_request(OP_TICK, 16'd1);
      drain();

      // random phases, rotating the idle patterns
      phase = 0;
      while (item_count < 1900) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         m = 3'($urandom_range(7));
         case ($urandom_range(9))
            0: d = '0;
            1: d = 24'hFF_FFFF;
            2: d = DUR_W'($urandom());
            default: d = DUR_W'($urandom_range(2000, 1));
         endcase
         configure(m, $urandom(), $urandom(), d);
         if (phase == 5) hold_off_go = 1'b1;
         n = $urandom_range(80, 30);
         for (int i = 0; i < n; i++) begin
            if (i == 0 || $urandom_range(99) < 8) send_request(OP_START, ELAPSED_W'($urandom()));
            else send_request(OP_TICK, pick_step());
            // pause once until the pipeline is empty
            if (phase == 7 && i == n / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (tracker.pending() != 0) @(posedge clock);
            end
         end
         drain();
         phase++;
      end

      drain();
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("timed_value_interpolator_tb: PASS");
      end else begin
         $display("timed_value_interpolator_tb: FAIL");
      end
      $finish;
   end

endmodule
